// ===== hdl/htb_pkg.sv =====
// Shared types and constants for the Huffman tree builder.
`default_nettype none

package htb_pkg;

  // Store capacity
  localparam int unsigned MAX_LEAVES = 4096;
  localparam int unsigned MAX_NODES  = 8191;

  // Field widths
  localparam int unsigned IDX_W    = 13;
  localparam int unsigned WEIGHT_W = 36;
  localparam int unsigned LEAF_W   = 24;
  localparam int unsigned KIND_W   = 2;

  // Node store word: open flag over the weight
  localparam int unsigned NODE_W = WEIGHT_W + 1;

  // Transaction kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MERGE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Merge status codes
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  localparam logic [IDX_W-1:0]    MAX_NODES_IDX  = IDX_W'(MAX_NODES);
  localparam logic [IDX_W-1:0]    MAX_LEAVES_IDX = IDX_W'(MAX_LEAVES);
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX     = {WEIGHT_W{1'b1}};

  typedef struct packed {
    logic                open;
    logic [WEIGHT_W-1:0] weight;
  } node_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN1,
    ST_SCAN2,
    ST_WR_A,
    ST_WR_B,
    ST_WR_K,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/huffman_tree_builder_top.sv =====
// Huffman tree builder: node store, two-pass minimum scan and merge sequencer.
// Load, clear and unused-kind transactions stay in the idle state; a new one is
// taken in the next cycle. A merge runs two scan passes over the stored nodes,
// three store writes and a result step, set by the single read port of the node
// store and one shared weight comparator. A refused merge skips to the result
// step. Reset clears the node counts; the store needs no clearing pass.
`default_nettype none

module huffman_tree_builder_top
  import htb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [KIND_W-1:0]   kind_i,
  input  wire logic [LEAF_W-1:0]   leaf_weight_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [IDX_W-1:0]    left_index_o,
  output logic      [IDX_W-1:0]    right_index_o,
  output logic      [IDX_W-1:0]    new_index_o,
  output logic      [WEIGHT_W-1:0] merged_weight_o,
  output logic                     is_root_o,
  output logic                     status_o
);

  state_e state_q, state_d;

  logic [IDX_W-1:0] node_count_q, node_count_d;
  logic [IDX_W-1:0] leaf_count_q, leaf_count_d;
  logic [IDX_W-1:0] open_count_q, open_count_d;

  // Scan state
  logic [IDX_W-1:0]    scan_q, scan_d;
  logic                rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]    rd_idx_q;
  logic                have_q, have_d;
  logic [IDX_W-1:0]    best_idx_q, best_idx_d;
  logic [WEIGHT_W-1:0] best_w_q, best_w_d;
  logic [IDX_W-1:0]    a_idx_q, a_idx_d;
  logic [WEIGHT_W-1:0] a_w_q, a_w_d;
  logic [IDX_W-1:0]    b_idx_q, b_idx_d;
  logic [WEIGHT_W-1:0] b_w_q, b_w_d;
  logic [WEIGHT_W-1:0] sum_q, sum_d;
  logic                refused_q, refused_d;

  // Output register
  logic                out_valid_q, out_valid_d;
  logic [IDX_W-1:0]    left_q, right_q, new_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic                root_q, status_q;
  logic                out_load;

  // Store port
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  node_t            ram_wdata;
  node_t            ram_rdata;
  logic             in_accept;
  logic             scan_last;
  logic             take;
  logic [WEIGHT_W:0] sum_raw;

  htb_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_addr_i (scan_q),
    .rd_data_o (ram_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign scan_last  = (scan_q == node_count_q);

  // Shared comparator: take an open node that beats the current best
  assign take = rd_vld_q && ram_rdata.open
             && !((state_q == ST_SCAN2) && (rd_idx_q == a_idx_q))
             && (!have_q || (ram_rdata.weight < best_w_q));

  // Shared adder with saturation
  assign sum_raw = {1'b0, a_w_q} + {1'b0, b_w_q};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (kind_i == KIND_MERGE)) begin
          if ((open_count_q < IDX_W'(2)) || (node_count_q >= MAX_NODES_IDX)) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SCAN1;
          end
        end
      end
      ST_SCAN1: if (scan_last) state_d = ST_SCAN2;
      ST_SCAN2: if (scan_last) state_d = ST_WR_A;
      ST_WR_A:  state_d = ST_WR_B;
      ST_WR_B:  state_d = ST_WR_K;
      ST_WR_K:  state_d = ST_FINISH;
      ST_FINISH: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    node_count_d = node_count_q;
    leaf_count_d = leaf_count_q;
    open_count_d = open_count_q;
    scan_d       = scan_q;
    rd_vld_d     = 1'b0;
    have_d       = have_q;
    best_idx_d   = take ? rd_idx_q : best_idx_q;
    best_w_d     = take ? ram_rdata.weight : best_w_q;
    a_idx_d      = a_idx_q;
    a_w_d        = a_w_q;
    b_idx_d      = b_idx_q;
    b_w_d        = b_w_q;
    sum_d        = sum_q;
    refused_d    = refused_q;
    ram_we       = 1'b0;
    ram_waddr    = node_count_q;
    ram_wdata    = '{open: 1'b1, weight: WEIGHT_W'(leaf_weight_i)};
    out_load     = 1'b0;
    if (take) have_d = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (kind_i)
            KIND_LOAD: begin
              // Append a leaf when there is room
              if ((leaf_count_q < MAX_LEAVES_IDX) && (node_count_q < MAX_NODES_IDX)) begin
                ram_we       = 1'b1;
                node_count_d = node_count_q + IDX_W'(1);
                leaf_count_d = leaf_count_q + IDX_W'(1);
                open_count_d = open_count_q + IDX_W'(1);
              end
            end
            KIND_MERGE: begin
              refused_d = (open_count_q < IDX_W'(2)) || (node_count_q >= MAX_NODES_IDX);
              scan_d    = '0;
              have_d    = 1'b0;
            end
            KIND_CLEAR: begin
              node_count_d = '0;
              leaf_count_d = '0;
              open_count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN1, ST_SCAN2: begin
        // Issue the next read and fold in the previous one
        if (!scan_last) begin
          rd_vld_d = 1'b1;
          scan_d   = scan_q + IDX_W'(1);
        end else begin
          scan_d = '0;
          have_d = 1'b0;
          if (state_q == ST_SCAN1) begin
            a_idx_d = best_idx_d;
            a_w_d   = best_w_d;
          end else begin
            b_idx_d = best_idx_d;
            b_w_d   = best_w_d;
          end
        end
      end
      ST_WR_A: begin
        // Close left child, form the saturated sum
        ram_we    = 1'b1;
        ram_waddr = a_idx_q;
        ram_wdata = '{open: 1'b0, weight: a_w_q};
        sum_d     = sum_raw[WEIGHT_W] ? WEIGHT_MAX : sum_raw[WEIGHT_W-1:0];
      end
      ST_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = b_idx_q;
        ram_wdata = '{open: 1'b0, weight: b_w_q};
      end
      ST_WR_K: begin
        // Append the open parent node
        ram_we       = 1'b1;
        ram_waddr    = node_count_q;
        ram_wdata    = '{open: 1'b1, weight: sum_q};
        node_count_d = node_count_q + IDX_W'(1);
        open_count_d = open_count_q - IDX_W'(1);
      end
      ST_FINISH: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
      end
    endcase
  end

  // Hold the result until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_count_q <= '0;
      leaf_count_q <= '0;
      open_count_q <= '0;
      rd_vld_q     <= 1'b0;
      have_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      node_count_q <= node_count_d;
      leaf_count_q <= leaf_count_d;
      open_count_q <= open_count_d;
      rd_vld_q     <= rd_vld_d;
      have_q       <= have_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    rd_idx_q   <= scan_q;
    best_idx_q <= best_idx_d;
    best_w_q   <= best_w_d;
    a_idx_q    <= a_idx_d;
    a_w_q      <= a_w_d;
    b_idx_q    <= b_idx_d;
    b_w_q      <= b_w_d;
    sum_q      <= sum_d;
    refused_q  <= refused_d;
    if (out_load) begin
      if (refused_q) begin
        left_q   <= '0;
        right_q  <= '0;
        new_q    <= '0;
        weight_q <= '0;
        root_q   <= 1'b0;
        status_q <= STATUS_REFUSED;
      end else begin
        left_q   <= a_idx_q;
        right_q  <= b_idx_q;
        new_q    <= node_count_q - IDX_W'(1);
        weight_q <= sum_q;
        root_q   <= (open_count_q == IDX_W'(1));
        status_q <= STATUS_DONE;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_index_o    = left_q;
  assign right_index_o   = right_q;
  assign new_index_o     = new_q;
  assign merged_weight_o = weight_q;
  assign is_root_o       = root_q;
  assign status_o        = status_q;

endmodule

`default_nettype wire

// ===== hdl/htb_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module htb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/htb_checker.sv =====
// Port-level checker for the Huffman tree builder, bound to the top level.
`default_nettype none

module htb_checker
  import htb_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic [KIND_W-1:0]   kind_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [IDX_W-1:0]    left_index_o,
  input wire logic [IDX_W-1:0]    right_index_o,
  input wire logic [IDX_W-1:0]    new_index_o,
  input wire logic [WEIGHT_W-1:0] merged_weight_o,
  input wire logic                is_root_o,
  input wire logic                status_o
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_index_o)
      && $stable(right_index_o) && $stable(new_index_o)
      && $stable(merged_weight_o) && $stable(is_root_o) && $stable(status_o))
    else $error("result changed while stalled");

  // A merge transaction keeps the input side busy next cycle
  a_merge_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (kind_i == KIND_MERGE) |=> in_stall_o)
    else $error("input taken right after a merge");

  // A refused merge reports zeros
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_REFUSED) |->
      (left_index_o == '0) && (right_index_o == '0) && (new_index_o == '0)
      && (merged_weight_o == '0) && !is_root_o)
    else $error("refused merge with nonzero fields");

  // A merge takes two distinct older nodes
  a_merge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_DONE) |->
      (left_index_o != right_index_o) && (left_index_o < new_index_o)
      && (right_index_o < new_index_o))
    else $error("bad child indexes");

endmodule

bind huffman_tree_builder_top htb_checker u_htb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .kind_i          (kind_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .left_index_o    (left_index_o),
  .right_index_o   (right_index_o),
  .new_index_o     (new_index_o),
  .merged_weight_o (merged_weight_o),
  .is_root_o       (is_root_o),
  .status_o        (status_o)
);

`default_nettype wire

// ===== sim/huffman_tree_builder_top_tb.sv =====
// Self-checking testbench for the Huffman tree builder: loads, merges, clears and refusals.
module huffman_tree_builder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import htb_pkg::*;

  // Kind code the block ignores
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int GAP_PCT      = 30;
  localparam int QUIET_FROM   = 1000;
  localparam int QUIET_TO     = 4000;
  localparam int RAND_ITEMS   = 70;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [LEAF_W-1:0] weight;
  } tree_op_t;

  typedef struct {
    logic [IDX_W-1:0]    left_idx;
    logic [IDX_W-1:0]    right_idx;
    logic [IDX_W-1:0]    new_idx;
    logic [WEIGHT_W-1:0] sum;
    logic                root;
    logic                status;
  } merge_res_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   kind        = KIND_LOAD;
  logic [LEAF_W-1:0]   leaf_weight = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [IDX_W-1:0]    left_index;
  logic [IDX_W-1:0]    right_index;
  logic [IDX_W-1:0]    new_index;
  logic [WEIGHT_W-1:0] merged_weight;
  logic                is_root;
  logic                status;

  // Stimulus feed and expected merge results
  tree_op_t   tree_ops_q[$];
  merge_res_t merge_due_q[$];
  tree_op_t   next_op;
  merge_res_t result_want;

  // Predicted node store
  logic [WEIGHT_W-1:0] tree_w [MAX_NODES];
  bit                  tree_open [MAX_NODES];
  int                  tree_nodes  = 0;
  int                  tree_leaves = 0;

  int  cyc_cnt    = 0;
  bit  in_taken   = 1'b0;
  bit  gaps_on    = 1'b1;
  int  mismatches = 0;
  int  n_loads    = 0;
  int  n_dropped  = 0;
  int  n_clears   = 0;
  int  n_unused   = 0;
  int  n_merges   = 0;
  int  n_refused  = 0;
  int  n_roots    = 0;

  huffman_tree_builder_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .kind_i          (kind),
    .leaf_weight_i   (leaf_weight),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .left_index_o    (left_index),
    .right_index_o   (right_index),
    .new_index_o     (new_index),
    .merged_weight_o (merged_weight),
    .is_root_o       (is_root),
    .status_o        (status)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Lowest-index smallest open node, excluding skip; -1 when there is none
  function automatic int pick_smallest(input int skip);
    int best;
    best = -1;
    for (int i = 0; i < tree_nodes; i++) begin
      if (tree_open[i] && i != skip && (best < 0 || tree_w[i] < tree_w[best])) begin
        best = i;
      end
    end
    return best;
  endfunction

  // Update the predicted store for one accepted transaction
  task automatic predict_op(input tree_op_t op);
    merge_res_t        res;
    logic [WEIGHT_W:0] total;
    int                lo_a;
    int                lo_b;
    int                open_cnt;
    res = '{left_idx: '0, right_idx: '0, new_idx: '0, sum: '0, root: 1'b0,
            status: STATUS_DONE};
    case (op.kind)
      KIND_LOAD: begin
        if (tree_leaves < MAX_LEAVES && tree_nodes < MAX_NODES) begin
          tree_w[tree_nodes]    = WEIGHT_W'(op.weight);
          tree_open[tree_nodes] = 1'b1;
          tree_nodes++;
          tree_leaves++;
          n_loads++;
        end else begin
          n_dropped++;
        end
      end
      KIND_CLEAR: begin
        foreach (tree_open[i]) tree_open[i] = 1'b0;
        tree_nodes  = 0;
        tree_leaves = 0;
        n_clears++;
      end
      KIND_MERGE: begin
        lo_a = pick_smallest(-1);
        lo_b = (lo_a < 0) ? -1 : pick_smallest(lo_a);
        if (tree_nodes >= MAX_NODES || lo_b < 0) begin
          res.status = STATUS_REFUSED;
          n_refused++;
        end else begin
          total = {1'b0, tree_w[lo_a]} + {1'b0, tree_w[lo_b]};
          // saturate the parent weight
          if (total[WEIGHT_W]) total = {1'b0, WEIGHT_MAX};
          tree_open[lo_a]       = 1'b0;
          tree_open[lo_b]       = 1'b0;
          tree_w[tree_nodes]    = total[WEIGHT_W-1:0];
          tree_open[tree_nodes] = 1'b1;
          res.left_idx  = IDX_W'(lo_a);
          res.right_idx = IDX_W'(lo_b);
          res.new_idx   = IDX_W'(tree_nodes);
          res.sum       = total[WEIGHT_W-1:0];
          tree_nodes++;
          open_cnt = 0;
          for (int i = 0; i < tree_nodes; i++) open_cnt += tree_open[i];
          res.root = (open_cnt == 1);
          if (res.root) n_roots++;
        end
        n_merges++;
        merge_due_q.push_back(res);
      end
      default: begin
        n_unused++;
      end
    endcase
  endtask

  task automatic queue_op(input logic [KIND_W-1:0] k, input logic [LEAF_W-1:0] w);
    tree_op_t op;
    op.kind   = k;
    op.weight = w;
    tree_ops_q.push_back(op);
  endtask

  // Driver: present the next transaction at the falling edge, idle and stall at random
  always @(negedge clk_i) begin
    gaps_on = (cyc_cnt < QUIET_FROM) || (cyc_cnt >= QUIET_TO);
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tree_ops_q.size() != 0 && !(gaps_on && $urandom_range(0, 99) < GAP_PCT)) begin
        next_op = tree_ops_q.pop_front();
        in_valid    <= 1'b1;
        kind        <= next_op.kind;
        leaf_weight <= next_op.weight;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_ni && gaps_on && ($urandom_range(0, 99) < GAP_PCT);
  end

  // Monitor: predict on accepted input, check accepted results against the oldest expectation
  always @(posedge clk_i) begin
    cyc_cnt++;
    in_taken = rst_ni && in_valid && !in_stall;
    if (in_taken) begin
      next_op.kind   = kind;
      next_op.weight = leaf_weight;
      predict_op(next_op);
    end
    if (rst_ni && out_valid && !out_stall) begin
      if (merge_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result with no merge pending: left %0d right %0d new %0d status %0b",
                   $time, left_index, right_index, new_index, status);
        end
      end else begin
        result_want = merge_due_q.pop_front();
        if (result_want.left_idx !== left_index || result_want.right_idx !== right_index ||
            result_want.new_idx !== new_index || result_want.sum !== merged_weight ||
            result_want.root !== is_root || result_want.status !== status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: merge result mismatch", $time);
            $display("  expected left %0d right %0d new %0d weight %0d root %0b status %0b",
                     result_want.left_idx, result_want.right_idx, result_want.new_idx,
                     result_want.sum, result_want.root, result_want.status);
            $display("  actual   left %0d right %0d new %0d weight %0d root %0b status %0b",
                     left_index, right_index, new_index, merged_weight, is_root, status);
          end
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int n_rand;
    int leaves;
    bit ties;
    n_rand = 0;

    // Directed: refusals, ties, root, leaf after merges, unused kind, clear
    queue_op(KIND_MERGE, '0);
    queue_op(KIND_LOAD, '1);
    queue_op(KIND_MERGE, '0);
    queue_op(KIND_LOAD, '0);
    queue_op(KIND_LOAD, 24'd5);
    queue_op(KIND_LOAD, 24'd5);
    queue_op(KIND_MERGE, '0);
    queue_op(KIND_MERGE, '1);
    queue_op(KIND_UNUSED, '1);
    queue_op(KIND_MERGE, '0);
    queue_op(KIND_MERGE, '0);
    queue_op(KIND_LOAD, 24'd7);
    queue_op(KIND_MERGE, '0);
    queue_op(KIND_CLEAR, '1);
    queue_op(KIND_MERGE, '0);
    queue_op(KIND_LOAD, 24'd3);
    queue_op(KIND_LOAD, 24'd3);
    queue_op(KIND_LOAD, 24'd3);
    queue_op(KIND_MERGE, '0);
    queue_op(KIND_MERGE, '0);

    // Random trees: load a few leaves, merge them down, some extra loads and noise
    while (n_rand < RAND_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        queue_op(KIND_CLEAR, LEAF_W'($urandom));
        n_rand++;
      end
      leaves = $urandom_range(2, 12);
      ties   = ($urandom_range(0, 2) == 0);
      repeat (leaves) begin
        queue_op(KIND_LOAD, ties ? LEAF_W'($urandom_range(0, 3)) : LEAF_W'($urandom));
        n_rand++;
      end
      repeat (leaves - 1 + $urandom_range(0, 1)) begin
        queue_op(KIND_MERGE, LEAF_W'($urandom));
        n_rand++;
        if ($urandom_range(0, 5) == 0) begin
          queue_op(KIND_LOAD, LEAF_W'($urandom));
          n_rand++;
        end
        if ($urandom_range(0, 9) == 0) queue_op(KIND_UNUSED, LEAF_W'($urandom));
      end
    end

    // Hold reset, then release away from the rising edge
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the feed to drain, the block to go idle and every merge result to arrive
    @(posedge clk_i);
    while (tree_ops_q.size() != 0 || in_valid || in_stall || merge_due_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d leaf loads, %0d loads dropped at capacity, %0d clears, %0d unused kinds.",
             n_loads, n_dropped, n_clears, n_unused);
    $display("Checked %0d merges: %0d refused, %0d closing a tree at its root.",
             n_merges, n_refused, n_roots);
    if (mismatches == 0) begin
      $display("[huffman_tree_builder_top] OK");
    end else begin
      $display("%0d result mismatches", mismatches);
      $display("[huffman_tree_builder_top] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d merge results outstanding", merge_due_q.size());
    $display("[huffman_tree_builder_top] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/htb_pkg.sv
hdl/htb_ram.sv
hdl/huffman_tree_builder_top.sv
hdl/htb_checker.sv
sim/huffman_tree_builder_top_tb.sv
